FILE: src/gra_pkg.sv
// ----------------------------------------------------------------------------
// gra_pkg
// Shared types and constants for the graph reachability search core.
// ----------------------------------------------------------------------------
`default_nettype none

package gra_pkg;

   // Node indices on the request and response ports are fixed at six bits.
   localparam int IDX_W         = 6;
   localparam int IDX_LIMIT     = 64;
   localparam int DEF_MAX_NODES = 64;

   typedef enum logic [1:0] {
      CMD_ADD_NODE    = 2'd0,
      CMD_ADD_EDGE    = 2'd1,
      CMD_REMOVE_EDGE = 2'd2,
      CMD_SEARCH      = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EDGE_A,
      ST_EDGE_RDB,
      ST_EDGE_B,
      ST_PUSH,
      ST_TOP,
      ST_ROW,
      ST_REPLY
   } state_type;

endpackage : gra_pkg

`default_nettype wire

FILE: src/gra_ram.sv
// ----------------------------------------------------------------------------
// gra_ram
// Simple dual-port synchronous RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gra_ram
   import gra_pkg::*;
#(
   parameter int WIDTH = IDX_W,
   parameter int DEPTH = DEF_MAX_NODES,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule : gra_ram

`default_nettype wire

FILE: src/graph_reachability_dfs_core.sv
// ----------------------------------------------------------------------------
// graph_reachability_dfs_core
// Undirected graph held as an adjacency bit matrix in RAM, with add node,
// add edge, remove edge and depth-first reachability search commands.
// ----------------------------------------------------------------------------
// Add or remove edge: read row a, write it back, then read and write row b.
// Search: each pop costs one stack RAM read and one adjacency RAM read in
//   series; each pending neighbour is then pushed in turn.
// Throughput: one request at a time; the next is taken once the response
//   has been loaded into the output register.
// Reset: synchronous; clears node count, stack pointer and control state.
//   No RAM clearing pass: a row is zeroed when its node is added.
`default_nettype none

module graph_reachability_dfs_core
   import gra_pkg::*;
#(
   parameter int MAX_NODES = DEF_MAX_NODES
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // request channel
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [1:0]       req_command,
   input  wire logic [IDX_W-1:0] req_node_a,
   input  wire logic [IDX_W-1:0] req_node_b,
   // response channel
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic                  rsp_reachable,
   output logic      [IDX_W-1:0] rsp_new_index,
   output logic                  rsp_error
);

   // Table capacity is bounded by the six-bit node index.
   localparam int CAP = (MAX_NODES < IDX_LIMIT) ? MAX_NODES : IDX_LIMIT;
   localparam int AW  = $clog2(CAP);
   localparam int CW  = $clog2(CAP + 1);

   typedef logic [CAP-1:0] row_type;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type        state_ff, state_in;
   logic [CW-1:0]    node_count_ff, node_count_in;
   logic [CW-1:0]    sp_ff, sp_in;
   row_type          visited_ff, visited_in;
   row_type          fresh_ff, fresh_in;
   cmd_type          cmd_ff, cmd_in;
   logic [IDX_W-1:0] a_ff, a_in;
   logic [IDX_W-1:0] b_ff, b_in;
   logic             res_reach_ff, res_reach_in;
   logic [IDX_W-1:0] res_index_ff, res_index_in;
   logic             res_err_ff, res_err_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_reach_ff, rsp_reach_in;
   logic [IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic             rsp_err_ff, rsp_err_in;

   // ---------------------------------------------------------------------
   // RAM ports
   // ---------------------------------------------------------------------
   logic          adj_wr_en, adj_rd_en;
   logic [AW-1:0] adj_wr_addr, adj_rd_addr;
   row_type       adj_wr_data, adj_rd_data;
   logic          stk_wr_en, stk_rd_en;
   logic [AW-1:0] stk_wr_addr, stk_rd_addr;
   logic [AW-1:0] stk_wr_data, stk_rd_data;

   gra_ram #(
      .WIDTH (CAP),
      .DEPTH (CAP)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_wr_en),
      .wr_addr (adj_wr_addr),
      .wr_data (adj_wr_data),
      .rd_en   (adj_rd_en),
      .rd_addr (adj_rd_addr),
      .rd_data (adj_rd_data)
   );

   gra_ram #(
      .WIDTH (AW),
      .DEPTH (CAP)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   // ---------------------------------------------------------------------
   // Request decode
   // ---------------------------------------------------------------------
   logic    req_fire;
   cmd_type req_cmd;
   logic    table_full;
   logic    bad_index;
   logic    slot_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_fire   = req_valid && !req_stall;
   assign req_cmd    = cmd_type'(req_command);
   assign table_full = (node_count_ff == CW'(CAP));
   // Either end must name a node that has already been added.
   assign bad_index  = ({1'b0, req_node_a} >= (IDX_W + 1)'(node_count_ff)) ||
                       ({1'b0, req_node_b} >= (IDX_W + 1)'(node_count_ff));
   // The output register can take a new response this cycle.
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------
   // Walk helpers
   // ---------------------------------------------------------------------
   logic [AW-1:0] push_idx;
   logic          fresh_any;
   logic          node_is_goal;
   row_type       row_fresh;

   // Lowest pending neighbour goes on the stack first.
   always_comb begin
      push_idx = '0;
      for (int i = CAP - 1; i >= 0; i--) begin
         if (fresh_ff[i]) begin
            push_idx = AW'(i);
         end
      end
   end

   assign fresh_any    = (fresh_ff != '0);
   assign node_is_goal = (IDX_W'(stk_rd_data) == b_ff);
   assign row_fresh    = adj_rd_data & ~visited_ff;

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_cmd == CMD_ADD_NODE || bad_index) begin
                  state_in = ST_REPLY;
               end else if (req_cmd == CMD_SEARCH) begin
                  state_in = ST_PUSH;
               end else begin
                  state_in = ST_EDGE_A;
               end
            end
         end
         ST_EDGE_A:   state_in = ST_EDGE_RDB;
         ST_EDGE_RDB: state_in = ST_EDGE_B;
         ST_EDGE_B:   state_in = ST_REPLY;
         ST_PUSH: begin
            if (!fresh_any) begin
               state_in = (sp_ff == '0) ? ST_REPLY : ST_TOP;
            end
         end
         ST_TOP:      state_in = node_is_goal ? ST_REPLY : ST_ROW;
         ST_ROW:      state_in = ST_PUSH;
         ST_REPLY: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath and RAM control
   // ---------------------------------------------------------------------
   always_comb begin
      node_count_in = node_count_ff;
      sp_in         = sp_ff;
      visited_in    = visited_ff;
      fresh_in      = fresh_ff;
      cmd_in        = cmd_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      res_reach_in  = res_reach_ff;
      res_index_in  = res_index_ff;
      res_err_in    = res_err_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_reach_in  = rsp_reach_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_err_in    = rsp_err_ff;

      adj_wr_en     = 1'b0;
      adj_wr_addr   = AW'(a_ff);
      adj_wr_data   = '0;
      adj_rd_en     = 1'b0;
      adj_rd_addr   = AW'(req_node_a);
      stk_wr_en     = 1'b0;
      stk_wr_addr   = sp_ff[AW-1:0];
      stk_wr_data   = push_idx;
      stk_rd_en     = 1'b0;
      stk_rd_addr   = AW'(sp_ff - CW'(1));

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in       = req_cmd;
               a_in         = req_node_a;
               b_in         = req_node_b;
               res_reach_in = 1'b0;
               res_index_in = '0;
               res_err_in   = 1'b0;
               if (req_cmd == CMD_ADD_NODE) begin
                  if (table_full) begin
                     res_err_in = 1'b1;
                  end else begin
                     // Zero the new node's row as it is handed out.
                     adj_wr_en     = 1'b1;
                     adj_wr_addr   = AW'(node_count_ff);
                     adj_wr_data   = '0;
                     res_index_in  = IDX_W'(node_count_ff);
                     node_count_in = node_count_ff + CW'(1);
                  end
               end else if (bad_index) begin
                  res_err_in = 1'b1;
               end else if (req_cmd == CMD_SEARCH) begin
                  // Seed the walk: the start node is the only pending push.
                  visited_in = row_type'(1) << req_node_a;
                  fresh_in   = row_type'(1) << req_node_a;
                  sp_in      = '0;
               end else begin
                  adj_rd_en   = 1'b1;
                  adj_rd_addr = AW'(req_node_a);
               end
            end
         end
         ST_EDGE_A: begin
            adj_wr_en   = 1'b1;
            adj_wr_addr = AW'(a_ff);
            adj_wr_data = (cmd_ff == CMD_ADD_EDGE) ?
                          (adj_rd_data |  (row_type'(1) << b_ff)) :
                          (adj_rd_data & ~(row_type'(1) << b_ff));
         end
         ST_EDGE_RDB: begin
            // Read row b only after row a is written back, so a self edge
            // sees its own update.
            adj_rd_en   = 1'b1;
            adj_rd_addr = AW'(b_ff);
         end
         ST_EDGE_B: begin
            adj_wr_en   = 1'b1;
            adj_wr_addr = AW'(b_ff);
            adj_wr_data = (cmd_ff == CMD_ADD_EDGE) ?
                          (adj_rd_data |  (row_type'(1) << a_ff)) :
                          (adj_rd_data & ~(row_type'(1) << a_ff));
         end
         ST_PUSH: begin
            if (fresh_any) begin
               stk_wr_en = 1'b1;
               sp_in     = sp_ff + CW'(1);
               fresh_in  = fresh_ff & (fresh_ff - row_type'(1));
            end else if (sp_ff == '0) begin
               res_reach_in = 1'b0;
            end else begin
               // Pop: the top entry arrives next cycle.
               stk_rd_en = 1'b1;
               sp_in     = sp_ff - CW'(1);
            end
         end
         ST_TOP: begin
            if (node_is_goal) begin
               res_reach_in = 1'b1;
            end else begin
               adj_rd_en   = 1'b1;
               adj_rd_addr = stk_rd_data;
            end
         end
         ST_ROW: begin
            // Mark every new neighbour now; each is pushed exactly once.
            fresh_in   = row_fresh;
            visited_in = visited_ff | adj_rd_data;
         end
         ST_REPLY: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_reach_in = res_reach_ff;
               rsp_index_in = res_index_ff;
               rsp_err_in   = res_err_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= '0;
         sp_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         sp_ff         <= sp_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      visited_ff   <= visited_in;
      fresh_ff     <= fresh_in;
      cmd_ff       <= cmd_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      res_reach_ff <= res_reach_in;
      res_index_ff <= res_index_in;
      res_err_ff   <= res_err_in;
      rsp_reach_ff <= rsp_reach_in;
      rsp_index_ff <= rsp_index_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_reachable = rsp_reach_ff;
   assign rsp_new_index = rsp_index_ff;
   assign rsp_error     = rsp_err_ff;

`ifndef SYNTHESIS
   // The stack can never hold more entries than the table capacity.
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= CW'(CAP))
      else $error("stack pointer beyond capacity");

   // Every pending push has already been marked visited.
   a_fresh_marked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH) |-> ((fresh_ff & ~visited_ff) == '0))
      else $error("pending push not marked visited");

   // A response never reports both an error and a reachable goal.
   a_rsp_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_err_ff && rsp_reach_ff))
      else $error("error and reachable both set");

   // The node count only grows by one, and only on an accepted add.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (node_count_ff != $past(node_count_ff)) |->
         (node_count_ff == $past(node_count_ff) + CW'(1)))
      else $error("node count moved by other than one");
`endif

endmodule : graph_reachability_dfs_core

`default_nettype wire
